[src/aes_pkg.sv]
package aes_pkg;

   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   typedef struct packed {
      block_type state;
      block_type rkey;
   } round_data_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type t [256];
      t = '{
         8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5, 8'h30, 8'h01, 8'h67, 8'h2B,
         8'hFE, 8'hD7, 8'hAB, 8'h76, 8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
         8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0, 8'hB7, 8'hFD, 8'h93, 8'h26,
         8'h36, 8'h3F, 8'hF7, 8'hCC, 8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
         8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A, 8'h07, 8'h12, 8'h80, 8'hE2,
         8'hEB, 8'h27, 8'hB2, 8'h75, 8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
         8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84, 8'h53, 8'hD1, 8'h00, 8'hED,
         8'h20, 8'hFC, 8'hB1, 8'h5B, 8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
         8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85, 8'h45, 8'hF9, 8'h02, 8'h7F,
         8'h50, 8'h3C, 8'h9F, 8'hA8, 8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
         8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2, 8'hCD, 8'h0C, 8'h13, 8'hEC,
         8'h5F, 8'h97, 8'h44, 8'h17, 8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
         8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88, 8'h46, 8'hEE, 8'hB8, 8'h14,
         8'hDE, 8'h5E, 8'h0B, 8'hDB, 8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
         8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79, 8'hE7, 8'hC8, 8'h37, 8'h6D,
         8'h8D, 8'hD5, 8'h4E, 8'hA9, 8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
         8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6, 8'hE8, 8'hDD, 8'h74, 8'h1F,
         8'h4B, 8'hBD, 8'h8B, 8'h8A, 8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
         8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E, 8'hE1, 8'hF8, 8'h98, 8'h11,
         8'h69, 8'hD9, 8'h8E, 8'h94, 8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
         8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2D, 8'h0F,
         8'hB0, 8'h54, 8'hBB, 8'h16};
      return t[x];
   endfunction

   function automatic byte_type rcon(input logic [3:0] idx);
      byte_type r;
      case (idx)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1B;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
   endfunction

   // byte n of a block sits in bits 127-8n downto 120-8n
   function automatic byte_type get_byte(input block_type b, input int unsigned n);
      return b[127 - 8*n -: 8];
   endfunction

endpackage

[src/aes_round.sv]
module aes_round #(
   parameter int unsigned RoundIdx = 1
) (
   input  logic                    clock,
   input  logic                    enable,
   input  aes_pkg::round_data_type data_in,
   output aes_pkg::round_data_type data_out
);
   import aes_pkg::*;

   block_type sb_in;
   block_type mc_in;
   block_type rk_in;
   round_data_type data_ff;
   round_data_type data_in_next;

   // key schedule: next round key from current one
   always_comb begin
      byte_type t [4];
      byte_type w [16];
      for (int n = 0; n < 16; n++) begin
         w[n] = get_byte(data_in.rkey, n);
      end
      t[0] = sbox(w[13]) ^ rcon(4'(RoundIdx));
      t[1] = sbox(w[14]);
      t[2] = sbox(w[15]);
      t[3] = sbox(w[12]);
      for (int n = 0; n < 4; n++) begin
         w[n] = w[n] ^ t[n];
      end
      for (int n = 4; n < 16; n++) begin
         w[n] = w[n] ^ w[n - 4];
      end
      for (int n = 0; n < 16; n++) begin
         rk_in[127 - 8*n -: 8] = w[n];
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb_in[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(data_in.state, r + 4*((c + r) % 4)));
         end
      end
   end

   always_comb begin
      byte_type a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(sb_in, 4*c);
         a1 = get_byte(sb_in, 4*c + 1);
         a2 = get_byte(sb_in, 4*c + 2);
         a3 = get_byte(sb_in, 4*c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         mc_in[127 - 32*c -: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
         mc_in[127 - 32*c - 8 -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
         mc_in[127 - 32*c - 16 -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         mc_in[127 - 32*c - 24 -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
   end

   always_comb begin
      data_in_next.rkey  = rk_in;
      data_in_next.state = ((RoundIdx == NumRounds) ? sb_in : mc_in) ^ rk_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_next;
      end
   end

   assign data_out = data_ff;

endmodule

[src/aes128_block_encrypt.sv]
// AES-128 encryption, one 128-bit block per transaction, each with its own key.
// Fully unrolled: an input register (initial AddRoundKey), then one register
// stage per round, ten rounds with on-the-fly key expansion. One block is accepted
// every cycle while the output is not holding an untaken result. rsp_tready low while
// a result waits at the output freezes the whole pipeline, so nothing is lost.
module aes128_block_encrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,  // plain_hi, plain_lo, key_hi, key_lo
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata   // cipher_hi, cipher_lo
);
   import aes_pkg::*;

   localparam int unsigned Stages = NumRounds + 1;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic              advance;
   round_data_type    stage [Stages];
   round_data_type    entry_ff;
   block_type         plain;
   block_type         key;

   // stage advances unless the output holds an untaken result
   assign advance    = !valid_ff[Stages-1] || rsp_tready;
   assign req_tready = advance;

   assign plain = {req_tdata[63:0], req_tdata[127:64]};
   assign key   = {req_tdata[191:128], req_tdata[255:192]};

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff.state <= plain ^ key;
         entry_ff.rkey  <= key;
      end
   end

   assign stage[0] = entry_ff;

   for (genvar g = 1; g < Stages; g++) begin : g_round
      aes_round #(.RoundIdx(g)) u_round (
         .clock    (clock),
         .enable   (advance),
         .data_in  (stage[g-1]),
         .data_out (stage[g])
      );
   end

   assign valid_in = {valid_ff[Stages-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff[Stages-1];
   assign rsp_tdata  = {stage[Stages-1].state[63:0], stage[Stages-1].state[127:64]};

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import aes_pkg::*;

   localparam int NumRandom = 1750;
   localparam int QuietLimit = 20000;
   localparam int Latency = 11;

   typedef struct packed {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
   } block_req_t;

   typedef struct packed {
      logic [63:0] cipher_hi;
      logic [63:0] cipher_lo;
   } block_rsp_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;  // plain_hi, plain_lo, key_hi, key_lo
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;  // cipher_hi, cipher_lo

   block_req_t pending_blocks[$];
   block_rsp_t expected_ciphers[$];
   int   send_gap;
   int   recv_gap;
   int   errors;
   int   quiet_cycles;
   int   hold_off;
   bit   stim_done;
   bit   pause_req;
   bit   hold_req;

   aes128_block_encrypt i_dut (.*);

   // AES tables held locally for prediction
   logic [7:0] sub_lut [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
   logic [7:0] rc_lut [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                               8'h1B, 8'h36};

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic block_rsp_t encrypt_block(input block_req_t b);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] ks [176];
      logic [7:0] w [4];
      logic [7:0] a0, a1, a2, a3, all;
      block_rsp_t res;
      logic [127:0] pt, kk, ct;
      pt = {b.plain_hi, b.plain_lo};
      kk = {b.key_hi, b.key_lo};
      for (int n = 0; n < 16; n++) begin
         st[n] = pt[127-8*n -: 8];
         ks[n] = kk[127-8*n -: 8];
      end
      for (int p = 16; p < 176; p += 4) begin
         for (int j = 0; j < 4; j++) w[j] = ks[p-4+j];
         if (p % 16 == 0) begin
            w = '{sub_lut[ks[p-3]] ^ rc_lut[p/16-1], sub_lut[ks[p-2]], sub_lut[ks[p-1]],
                  sub_lut[ks[p-4]]};
         end
         for (int j = 0; j < 4; j++) ks[p+j] = ks[p-16+j] ^ w[j];
      end
      for (int n = 0; n < 16; n++) st[n] ^= ks[n];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) tmp[r+4*c] = sub_lut[st[r+4*((c+r)%4)]];
         st = tmp;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
            end
         end
         for (int n = 0; n < 16; n++) st[n] ^= ks[16*rnd+n];
      end
      for (int n = 0; n < 16; n++) ct[127-8*n -: 8] = st[n];
      res.cipher_hi = ct[127:64];
      res.cipher_lo = ct[63:0];
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_block(input logic [63:0] ph, pl, kh, kl);
      block_req_t b;
      b = '{ph, pl, kh, kl};
      pending_blocks.push_back(b);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // directed blocks: FIPS-197 vectors, zeros, ones, half-ones mixes, walking bits
   initial begin
      logic [63:0] v;
      stim_done = 1'b0;
      pause_req = 1'b0;
      hold_req = 1'b0;
      queue_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff,
                  64'h00010203_04050607, 64'h08090a0b_0c0d0e0f);
      queue_block('0, '0, '0, '0);
      queue_block('1, '1, '1, '1);
      queue_block('1, '1, '0, '0);
      queue_block('0, '0, '1, '1);
      for (int i = 0; i < 8; i++) begin
         v = 64'h1 << (i * 9);
         queue_block(v, ~v, v << 1, ~(v >> 1));
      end
      queue_block(64'h32_43_f6_a8_88_5a_30_8d, 64'h31_31_98_a2_e0_37_07_34,
                  64'h2b_7e_15_16_28_ae_d2_a6, 64'hab_f7_15_88_09_cf_4f_3c);
      wait (pending_blocks.size() == 0);
      // long receiver stall with the sender still offering
      hold_req = 1'b1;
      for (int i = 0; i < 60; i++) queue_block(rand64(), rand64(), rand64(), rand64());
      wait (pending_blocks.size() == 0 && hold_req == 1'b0);
      for (int i = 0; i < NumRandom; i++) begin
         if (i == NumRandom / 2) begin
            wait (pending_blocks.size() == 0);
            pause_req = 1'b1;
            wait (pause_req == 1'b0);
         end
         case ($urandom_range(0, 9))
            0:       queue_block(rand64(), rand64(), '0, '0);
            1:       queue_block('0, '0, rand64(), rand64());
            2:       queue_block('1, rand64(), '1, rand64());
            default: queue_block(rand64(), rand64(), rand64(), rand64());
         endcase
         if (pending_blocks.size() > 20) wait (pending_blocks.size() < 10);
      end
      wait (pending_blocks.size() == 0);
      stim_done = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold the transaction
      end else if (pause_req) begin
         req_tvalid <= 1'b0;
         if (expected_ciphers.size() == 0 && !req_tvalid) pause_req <= 1'b0;
      end else if (send_gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_blocks.size() > 0) begin
         block_req_t b;
         b = pending_blocks.pop_front();
         req_tdata <= {b.key_lo, b.key_hi, b.plain_lo, b.plain_hi};
         req_tvalid <= 1'b1;
         send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // predictor feed on accepted input transactions
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         block_req_t b;
         b.plain_hi = req_tdata[63:0];
         b.plain_lo = req_tdata[127:64];
         b.key_hi = req_tdata[191:128];
         b.key_lo = req_tdata[255:192];
         expected_ciphers.push_back(encrypt_block(b));
      end
   end

   // receiver ready control
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
         hold_off <= 0;
      end else if (hold_req) begin
         rsp_tready <= 1'b0;
         if (hold_off >= 200) begin
            hold_req <= 1'b0;
            hold_off <= 0;
         end else begin
            hold_off <= hold_off + 1;
         end
      end else if (recv_gap > 0) begin
         rsp_tready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (rsp_tvalid && rsp_tready) begin
         int g;
         g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
         // zero gap keeps ready high for back-to-back transactions
         recv_gap <= (g > 0) ? g - 1 : 0;
         rsp_tready <= (g == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         block_rsp_t got, exp_c;
         got = '{rsp_tdata[63:0], rsp_tdata[127:64]};
         if (expected_ciphers.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, got);
            errors++;
         end else begin
            exp_c = expected_ciphers.pop_front();
            if (got.cipher_hi !== exp_c.cipher_hi) begin
               $display("%0t: cipher_hi expected %h actual %h", $time, exp_c.cipher_hi,
                        got.cipher_hi);
               errors++;
            end
            if (got.cipher_lo !== exp_c.cipher_lo) begin
               $display("%0t: cipher_lo expected %h actual %h", $time, exp_c.cipher_lo,
                        got.cipher_lo);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      wait (stim_done);
      wait (expected_ciphers.size() == 0 && !req_tvalid);
      repeat (Latency * 3) @(posedge clock);
      if (errors == 0 && expected_ciphers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
src/aes_pkg.sv
src/aes_round.sv
src/aes128_block_encrypt.sv
dv/tb.sv
